>>> src/siph_pkg.sv
package siph_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [63:0] INIT_C0   = 64'h736f6d6570736575;
	localparam logic [63:0] INIT_C1   = 64'h646f72616e646f6d;
	localparam logic [63:0] INIT_C2   = 64'h6c7967656e657261;
	localparam logic [63:0] INIT_C3   = 64'h7465646279746573;
	localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} sip_state_t;

	// one word of work for the round engine
	typedef struct packed {
		logic [63:0] word;
		logic [63:0] key_low;
		logic [63:0] key_high;
		logic [7:0]  len;
		logic        start;
		logic        fin;
		logic        second;
	} sip_entry_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned s);
		return (x << s) | (x >> (64 - s));
	endfunction

	function automatic sip_state_t sip_round(input sip_state_t s);
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
		sip_state_t  r;
		v0 = s.v0;
		v1 = s.v1;
		v2 = s.v2;
		v3 = s.v3;
		v0 = v0 + v1;
		v2 = v2 + v3;
		v1 = rotl(v1, 13);
		v3 = rotl(v3, 16);
		v1 = v1 ^ v0;
		v3 = v3 ^ v2;
		v0 = rotl(v0, 32);
		v2 = v2 + v1;
		v0 = v0 + v3;
		v1 = rotl(v1, 17);
		v3 = rotl(v3, 21);
		v1 = v1 ^ v2;
		v3 = v3 ^ v0;
		v2 = rotl(v2, 32);
		r.v0 = v0;
		r.v1 = v1;
		r.v2 = v2;
		r.v3 = v3;
		return r;
	endfunction

	function automatic sip_state_t sip_init(input logic [63:0] klo, input logic [63:0] khi);
		sip_state_t r;
		r.v0 = klo ^ INIT_C0;
		r.v1 = khi ^ INIT_C1;
		r.v2 = klo ^ INIT_C2;
		r.v3 = khi ^ INIT_C3;
		return r;
	endfunction

endpackage

>>> src/siph_front.sv
module siph_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 msg_valid,
	output logic                 msg_ready,
	input  logic [7:0]           msg_byte,
	input  logic                 has_byte,
	input  logic                 last,
	input  logic [63:0]          key_low,
	input  logic [63:0]          key_high,
	input  logic                 q_full,
	output logic                 q_push,
	output siph_pkg::sip_entry_t q_entry
);

	logic [55:0] buf_q;
	logic [2:0]  biw_q;
	logic [7:0]  len_q;
	logic        open_q;
	logic        start_pend_q;
	logic [63:0] klo_q;
	logic [63:0] khi_q;

	logic        acc;
	logic        opening;
	logic [55:0] buf_cur;
	logic [2:0]  biw_cur;
	logic [7:0]  len_cur;
	logic [7:0]  len_nxt;
	logic [55:0] ins;
	logic        word_full;
	logic [55:0] buf_nxt;
	logic [2:0]  biw_nxt;

	assign msg_ready = !q_full;
	assign acc       = msg_valid && msg_ready;
	assign opening   = !open_q;

	always_comb begin
		buf_cur   = opening ? 56'd0 : buf_q;
		biw_cur   = opening ? 3'd0 : biw_q;
		len_cur   = opening ? 8'd0 : len_q;
		len_nxt   = len_cur + {7'd0, has_byte};
		ins       = 56'(msg_byte) << {biw_cur, 3'b000};
		word_full = has_byte && (biw_cur == 3'd7);
		if (word_full) begin
			buf_nxt = 56'd0;
			biw_nxt = 3'd0;
		end else if (has_byte) begin
			buf_nxt = buf_cur | ins;
			biw_nxt = biw_cur + 3'd1;
		end else begin
			buf_nxt = buf_cur;
			biw_nxt = biw_cur;
		end
		q_entry.word     = word_full ? {msg_byte, buf_cur} : {len_nxt, buf_nxt};
		q_entry.key_low  = opening ? key_low : klo_q;
		q_entry.key_high = opening ? key_high : khi_q;
		q_entry.len      = len_nxt;
		q_entry.start    = opening || start_pend_q;
		q_entry.fin      = last;
		q_entry.second   = word_full && last;
		q_push           = acc && (word_full || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biw_q        <= 3'd0;
			len_q        <= 8'd0;
			open_q       <= 1'b0;
			start_pend_q <= 1'b0;
		end else if (acc) begin
			biw_q        <= biw_nxt;
			len_q        <= len_nxt;
			open_q       <= !last;
			start_pend_q <= (opening || start_pend_q) && !q_push;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			buf_q <= buf_nxt;
			if (opening) begin
				klo_q <= key_low;
				khi_q <= key_high;
			end
		end
	end

endmodule

>>> src/siph_fifo.sv
module siph_fifo #(
	parameter int unsigned DEPTH = siph_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  siph_pkg::sip_entry_t push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output siph_pkg::sip_entry_t head
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	siph_pkg::sip_entry_t slots [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slots[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full)
		else $error("push into full queue");

endmodule

>>> src/siph_back.sv
module siph_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  siph_pkg::sip_entry_t q_head,
	output logic                 q_pop,
	output logic                 dig_valid,
	input  logic                 dig_ready,
	output logic [63:0]          digest
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_A1   = 2'd1;
	localparam logic [1:0] PH_A2   = 2'd2;
	localparam logic [1:0] PH_F    = 2'd3;

	logic [1:0]           phase_q;
	logic [1:0]           fcnt_q;
	logic                 fin_q;
	logic                 second_q;
	logic                 dig_valid_q;
	siph_pkg::sip_state_t v_q;
	logic [63:0]          m_q;
	logic [7:0]           len_q;
	logic [63:0]          digest_q;

	logic [1:0]           phase_d;
	logic [1:0]           fcnt_d;
	logic                 fin_d;
	logic                 second_d;
	logic                 dig_valid_d;
	siph_pkg::sip_state_t v_d;
	logic [63:0]          m_d;
	logic [7:0]           len_d;
	logic [63:0]          digest_d;

	siph_pkg::sip_state_t rin;
	siph_pkg::sip_state_t rout;
	logic                 out_free;
	logic                 can_pop;

	assign dig_valid = dig_valid_q;
	assign digest    = digest_q;

	always_comb begin
		rin = v_q;
		if (phase_q == PH_A1) begin
			rin.v3 = v_q.v3 ^ m_q;
		end
		rout     = siph_pkg::sip_round(rin);
		out_free = !dig_valid_q || dig_ready;
		can_pop  = (phase_q == PH_IDLE) || (phase_q == PH_A2 && !fin_q && !second_q);
		q_pop    = q_valid && can_pop;

		phase_d     = phase_q;
		fcnt_d      = fcnt_q;
		fin_d       = fin_q;
		second_d    = second_q;
		dig_valid_d = dig_valid_q && !dig_ready;
		v_d         = v_q;
		m_d         = m_q;
		len_d       = len_q;
		digest_d    = digest_q;

		unique case (phase_q)
			PH_IDLE: begin
				phase_d = PH_IDLE;
			end
			PH_A1: begin
				v_d     = rout;
				phase_d = PH_A2;
			end
			PH_A2: begin
				v_d    = rout;
				v_d.v0 = rout.v0 ^ m_q;
				if (second_q) begin
					m_d      = {len_q, 56'd0};
					second_d = 1'b0;
					phase_d  = PH_A1;
				end else if (fin_q) begin
					v_d.v2  = rout.v2 ^ siph_pkg::FINAL_XOR;
					fcnt_d  = 2'd0;
					phase_d = PH_F;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_F: begin
				if (fcnt_q != 2'd3) begin
					v_d    = rout;
					fcnt_d = fcnt_q + 2'd1;
				end else if (out_free) begin
					digest_d    = rout.v0 ^ rout.v1 ^ rout.v2 ^ rout.v3;
					dig_valid_d = 1'b1;
					fin_d       = 1'b0;
					phase_d     = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		if (q_pop) begin
			m_d      = q_head.word;
			len_d    = q_head.len;
			fin_d    = q_head.fin;
			second_d = q_head.second;
			phase_d  = PH_A1;
			if (q_head.start) begin
				v_d = siph_pkg::sip_init(q_head.key_low, q_head.key_high);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			fcnt_q      <= 2'd0;
			fin_q       <= 1'b0;
			second_q    <= 1'b0;
			dig_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			fcnt_q      <= fcnt_d;
			fin_q       <= fin_d;
			second_q    <= second_d;
			dig_valid_q <= dig_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		v_q      <= v_d;
		m_q      <= m_d;
		len_q    <= len_d;
		digest_q <= digest_d;
	end

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_head.start |-> phase_q == PH_IDLE)
		else $error("message start while engine busy");
	a_final_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_F |-> fin_q && !second_q)
		else $error("final rounds without final word");
	a_digest_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dig_valid_q) |-> $past(phase_q == PH_F && fcnt_q == 2'd3))
		else $error("digest raised outside last round");

endmodule

>>> src/siphash_2_4_mac.sv
// channel   direction  handshake            payload
// msg       in         msg_valid/msg_ready  msg_byte[7:0], has_byte, last
// dig       out        dig_valid/dig_ready  digest[63:0]
// apb       in         psel/penable/pready  paddr[3:0], pwdata/prdata[63:0]
//
// one message byte per cycle while the queue is not full; each full word and
// each final request go to the round engine through the queue; a final request
// that also closes a full word makes the engine absorb the length word after it
// the engine runs one sipround per cycle while busy, and holds before the digest while dig is full
// arst_n clears the keys, the queue and all control; no clearing pass
// the 2-entry queue lets the byte side run on while the engine or dig stalls
module siphash_2_4_mac #(
	parameter int unsigned QUEUE_DEPTH = siph_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_ready,
	input  logic [7:0]  msg_byte,
	input  logic        has_byte,
	input  logic        last,
	output logic        dig_valid,
	input  logic        dig_ready,
	output logic [63:0] digest,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	logic [63:0]          key_low_q;
	logic [63:0]          key_high_q;
	logic                 cfg_wr;
	logic                 q_full;
	logic                 q_push;
	logic                 q_pop;
	logic                 q_valid;
	siph_pkg::sip_entry_t q_entry;
	logic                 unused_addr;
	siph_pkg::sip_entry_t q_head;

	assign pready      = 1'b1;
	assign cfg_wr      = psel && penable && pwrite && pready;
	assign prdata      = (paddr[3] == REG_KEY_HIGH) ? key_high_q : key_low_q;
	assign unused_addr = ^paddr[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= 64'd0;
			key_high_q <= 64'd0;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				REG_KEY_LOW:  key_low_q  <= pwdata;
				REG_KEY_HIGH: key_high_q <= pwdata;
				default:      key_low_q  <= key_low_q;
			endcase
		end
	end

	siph_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg_byte  (msg_byte),
		.has_byte  (has_byte),
		.last      (last),
		.key_low   (key_low_q),
		.key_high  (key_high_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	siph_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	siph_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.digest    (digest)
	);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	typedef enum logic [3:0] {
		KEY_LOW_ADDR  = 4'h0,
		KEY_HIGH_ADDR = 4'h8
	} key_reg_e;

	typedef enum int {
		MATCH_OK,
		MATCH_NONE,
		MATCH_WRONG
	} match_e;

	class tag_predictor;
		bit [63:0] key_lo;
		bit [63:0] key_hi;
		bit [63:0] v0;
		bit [63:0] v1;
		bit [63:0] v2;
		bit [63:0] v3;
		bit [55:0] partial;
		bit [2:0]  fill;
		bit [7:0]  msg_len;
		bit        open;
		bit [63:0] expected_tags[$];

		function void set_key(key_reg_e r, bit [63:0] value);
			if (r == KEY_LOW_ADDR)
				key_lo = value;
			else
				key_hi = value;
		endfunction

		function bit [63:0] rol(bit [63:0] x, int s);
			return (x << s) | (x >> (64 - s));
		endfunction

		function void mix_round();
			v0 = v0 + v1;
			v2 = v2 + v3;
			v1 = rol(v1, 13);
			v3 = rol(v3, 16);
			v1 = v1 ^ v0;
			v3 = v3 ^ v2;
			v0 = rol(v0, 32);
			v2 = v2 + v1;
			v0 = v0 + v3;
			v1 = rol(v1, 17);
			v3 = rol(v3, 21);
			v1 = v1 ^ v2;
			v3 = v3 ^ v0;
			v2 = rol(v2, 32);
		endfunction

		function void absorb_word(bit [63:0] m);
			v3 = v3 ^ m;
			mix_round();
			mix_round();
			v0 = v0 ^ m;
		endfunction

		function void take_request(bit [7:0] b, bit h, bit l);
			if (!open) begin
				v0 = key_lo ^ siph_pkg::INIT_C0;
				v1 = key_hi ^ siph_pkg::INIT_C1;
				v2 = key_lo ^ siph_pkg::INIT_C2;
				v3 = key_hi ^ siph_pkg::INIT_C3;
				partial = '0;
				fill = '0;
				msg_len = '0;
				open = 1'b1;
			end
			if (h) begin
				if (fill == 3'd7) begin
					absorb_word({b, partial});
					partial = '0;
					fill = '0;
				end else begin
					partial = partial | (56'(b) << (8 * fill));
					fill = fill + 3'd1;
				end
				msg_len = msg_len + 8'd1;
			end
			if (l) begin
				absorb_word({msg_len, partial});
				v2 = v2 ^ siph_pkg::FINAL_XOR;
				repeat (4) mix_round();
				expected_tags.push_back(v0 ^ v1 ^ v2 ^ v3);
				partial = '0;
				fill = '0;
				msg_len = '0;
				open = 1'b0;
			end
		endfunction

		function match_e match_tag(bit [63:0] got, output bit [63:0] want);
			if (expected_tags.size() == 0) begin
				want = '0;
				return MATCH_NONE;
			end
			want = expected_tags.pop_front();
			return (got == want) ? MATCH_OK : MATCH_WRONG;
		endfunction

		function int pending();
			return expected_tags.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        msg_valid = 1'b0;
	logic        msg_ready;
	logic [7:0]  msg_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        last = 1'b0;
	logic        dig_valid;
	logic        dig_ready = 1'b0;
	logic [63:0] digest;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'h0;
	logic [63:0] pwdata = 64'h0;
	logic [63:0] prdata;
	logic        pready;

	tag_predictor sb = new;
	int errors = 0;
	int items_sent = 0;
	int send_calm = 0;
	int recv_calm = 0;

	siphash_2_4_mac u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg_byte  (msg_byte),
		.has_byte  (has_byte),
		.last      (last),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.digest    (digest),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm_left = $urandom_range(8, 40);
		return $urandom_range(0, 17);
	endfunction

	task automatic report_error(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		errors++;
	endtask

	task automatic send_request(input bit [7:0] b, input bit h, input bit l);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_valid <= 1'b1;
		msg_byte <= b;
		has_byte <= h;
		last <= l;
		do @(posedge clk); while (!msg_ready);
		sb.take_request(b, h, l);
		items_sent++;
	endtask

	task automatic wait_idle();
		msg_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_key(input key_reg_e r, input bit [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= r;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_key(r, value);
		@(posedge clk);
	endtask

	function automatic bit [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_message(input int n_bytes);
		bit tail_empty;
		tail_empty = (n_bytes == 0) || ($urandom_range(0, 5) == 0);
		for (int i = 0; i < n_bytes; i++) begin
			if ($urandom_range(0, 11) == 0)
				send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_request(pick_byte(), 1'b1, !tail_empty && (i == n_bytes - 1));
		end
		if (tail_empty)
			send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic run_phase(input int n_items, input int long_len);
		int stop_at;
		int r;
		stop_at = items_sent + n_items;
		if (long_len > 0)
			send_message(long_len);
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				send_message($urandom_range(0, 16));
			else if (r < 9)
				send_message($urandom_range(17, 64));
			else
				send_message($urandom_range(65, 120));
			if ($urandom_range(0, 24) == 0)
				wait_idle();
		end
		wait_idle();
	endtask

	// receive side
	initial begin
		bit [63:0] want;
		int stall;
		match_e st;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(recv_calm);
			if (stall > 0) begin
				dig_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dig_ready <= 1'b1;
			do @(posedge clk); while (!dig_valid);
			st = sb.match_tag(digest, want);
			if (st == MATCH_NONE)
				report_error($sformatf("digest %h with none expected", digest));
			else if (st == MATCH_WRONG)
				report_error($sformatf("digest mismatch: got %h want %h", digest, want));
		end
	end

	initial begin
		#(64'd10_000_000);
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset key
		send_request(8'h5a, 1'b0, 1'b1);
		send_request(8'hff, 1'b1, 1'b1);
		for (int i = 0; i < 8; i++)
			send_request(8'(i), 1'b1, i == 7);
		send_request(8'hff, 1'b0, 1'b0);
		send_request(8'h00, 1'b0, 1'b1);
		for (int i = 0; i < 9; i++) begin
			if (i == 4)
				send_request(8'ha5, 1'b0, 1'b0);
			send_request(8'(8'hf0 + i), 1'b1, i == 8);
		end
		send_request(8'h00, 1'b1, 1'b1);
		wait_idle();

		write_key(KEY_LOW_ADDR, 64'h0706050403020100);
		write_key(KEY_HIGH_ADDR, 64'h0f0e0d0c0b0a0908);
		run_phase(300, 256);

		write_key(KEY_LOW_ADDR, '1);
		write_key(KEY_HIGH_ADDR, '1);
		run_phase(300, 0);

		write_key(KEY_LOW_ADDR, {$urandom, $urandom});
		write_key(KEY_HIGH_ADDR, {$urandom, $urandom});
		run_phase(300, 300);

		write_key(KEY_LOW_ADDR, '1);
		write_key(KEY_HIGH_ADDR, '0);
		run_phase(300, 0);

		write_key(KEY_LOW_ADDR, '0);
		run_phase(250, 0);

		write_key(KEY_LOW_ADDR, {$urandom, $urandom});
		write_key(KEY_HIGH_ADDR, {$urandom, $urandom});
		run_phase(300, 0);

		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
src/siph_pkg.sv
src/siph_front.sv
src/siph_fifo.sv
src/siph_back.sv
src/siphash_2_4_mac.sv
tb/tb_top.sv
